### rtl/akv_pkg.sv
`timescale 1ns / 1ps
package akv_pkg;

   localparam int TEXT_W         = 7;
   localparam int KEY_BYTE_W     = 8;
   localparam int MAX_KEY_LENGTH = 16;
   localparam int PTR_W          = 4;
   localparam int POS_W          = 5;
   localparam int KEY_LEN_W      = 5;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_ADDR_W     = 5;
   localparam int SUM_W          = 10;

   localparam logic [TEXT_W-1:0]     NEWLINE_CHAR   = 7'd10;
   localparam logic [SUM_W-1:0]      ALPHA_SIZE     = 10'd96;
   localparam logic [SUM_W-1:0]      ALPHA_BASE     = 10'd32;
   // encrypt adds (p-32)+(s-32)+96*2, decrypt adds 96*3 to keep it positive
   localparam logic [SUM_W-1:0]      ENC_BIAS       = 10'd128;
   localparam logic [SUM_W-1:0]      DEC_BIAS       = 10'd288;

   localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RESET  = 5'd9;
   localparam logic [CSR_DATA_W-1:0] KEY_LOW_RESET  = 64'd8532478995116287332;
   localparam logic [CSR_DATA_W-1:0] KEY_HIGH_RESET = 64'd101;

   typedef enum logic {
      MODE_ENCRYPT = 1'b0,
      MODE_DECRYPT = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      REG_MODE       = 2'd0,
      REG_KEY_LENGTH = 2'd1,
      REG_KEY_LOW    = 2'd2,
      REG_KEY_HIGH   = 2'd3
   } reg_index_type;

   typedef struct packed {
      mode_type                mode;
      logic [KEY_LEN_W-1:0]    key_length;
      logic [CSR_DATA_W-1:0]   key_low_chars;
      logic [CSR_DATA_W-1:0]   key_high_chars;
   } cfg_type;

   // one character handed from the front to the back
   typedef struct packed {
      logic [TEXT_W-1:0]     text_char;
      mode_type              mode;
      logic                  use_key;
      logic [KEY_BYTE_W-1:0] key_byte;
      logic [PTR_W-1:0]      rd_idx;
      logic [PTR_W-1:0]      wr_idx;
   } work_type;

   // reduce a sum below 512 modulo 96 and move it into 32..127
   function automatic logic [TEXT_W-1:0] wrap_printable(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] r;
      r = sum;
      if (r >= SUM_W'(4 * ALPHA_SIZE)) begin
         r = r - SUM_W'(4 * ALPHA_SIZE);
      end
      if (r >= SUM_W'(2 * ALPHA_SIZE)) begin
         r = r - SUM_W'(2 * ALPHA_SIZE);
      end
      if (r >= ALPHA_SIZE) begin
         r = r - ALPHA_SIZE;
      end
      r = r + ALPHA_BASE;
      return r[TEXT_W-1:0];
   endfunction

endpackage

### rtl/akv_req_if.sv
`timescale 1ns / 1ps
interface akv_req_if;
   import akv_pkg::*;

   logic              valid;
   logic              ready;
   logic [TEXT_W-1:0] text_char;
   logic              first_of_message;

   modport source (output valid, output text_char, output first_of_message, input ready);
   modport sink   (input valid, input text_char, input first_of_message, output ready);
endinterface

### rtl/akv_rsp_if.sv
`timescale 1ns / 1ps
interface akv_rsp_if;
   import akv_pkg::*;

   logic              valid;
   logic              ready;
   logic [TEXT_W-1:0] out_char;

   modport source (output valid, output out_char, input ready);
   modport sink   (input valid, input out_char, output ready);
endinterface

### rtl/akv_csr.sv
`timescale 1ns / 1ps
module akv_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [akv_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [akv_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [akv_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output akv_pkg::cfg_type               cfg
);
   import akv_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_MODE:       cfg_in.mode           = mode_type'(csr_pwdata[0]);
            REG_KEY_LENGTH: cfg_in.key_length     = csr_pwdata[KEY_LEN_W-1:0];
            REG_KEY_LOW:    cfg_in.key_low_chars  = csr_pwdata;
            REG_KEY_HIGH:   cfg_in.key_high_chars = csr_pwdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_MODE:       csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.mode};
         REG_KEY_LENGTH: csr_prdata = {{(CSR_DATA_W-KEY_LEN_W){1'b0}}, cfg_ff.key_length};
         REG_KEY_LOW:    csr_prdata = cfg_ff.key_low_chars;
         REG_KEY_HIGH:   csr_prdata = cfg_ff.key_high_chars;
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= MODE_ENCRYPT;
         cfg_ff.key_length     <= KEY_LEN_RESET;
         cfg_ff.key_low_chars  <= KEY_LOW_RESET;
         cfg_ff.key_high_chars <= KEY_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

### rtl/akv_front.sv
`timescale 1ns / 1ps
module akv_front (
   input  logic              clock,
   input  logic              reset,
   akv_req_if.sink           req_link,
   input  akv_pkg::cfg_type  cfg,
   input  logic              q_full,
   output logic              q_push,
   output akv_pkg::work_type q_data
);
   import akv_pkg::*;

   logic [POS_W-1:0]      position_ff, position_in;
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic                  stopped_ff, stopped_in;
   logic [POS_W-1:0]      klen;
   logic [POS_W-1:0]      pos_now;
   logic                  stopped_now;
   logic                  accept;
   logic                  is_stop;
   logic [2*CSR_DATA_W-1:0] key_all;

   // clamp key length into 1..MAX_KEY_LENGTH
   always_comb begin
      if (cfg.key_length == '0) begin
         klen = POS_W'(1);
      end else if (cfg.key_length > POS_W'(MAX_KEY_LENGTH)) begin
         klen = POS_W'(MAX_KEY_LENGTH);
      end else begin
         klen = cfg.key_length;
      end
   end

   assign req_link.ready = !q_full;
   assign accept         = req_link.valid & req_link.ready;
   assign key_all        = {cfg.key_high_chars, cfg.key_low_chars};

   assign pos_now     = req_link.first_of_message ? '0 : position_ff;
   assign stopped_now = req_link.first_of_message ? 1'b0 : stopped_ff;
   assign is_stop     = (cfg.mode == MODE_ENCRYPT) && (req_link.text_char == NEWLINE_CHAR);

   always_comb begin
      q_data.text_char = req_link.text_char;
      q_data.mode      = cfg.mode;
      q_data.use_key   = pos_now < klen;
      q_data.key_byte  = key_all[pos_now[PTR_W-1:0]*KEY_BYTE_W +: KEY_BYTE_W];
      q_data.rd_idx    = wr_ptr_ff - klen[PTR_W-1:0];
      q_data.wr_idx    = wr_ptr_ff;
   end

   always_comb begin
      q_push      = 1'b0;
      position_in = position_ff;
      wr_ptr_in   = wr_ptr_ff;
      stopped_in  = stopped_ff;
      if (accept) begin
         position_in = pos_now;
         stopped_in  = stopped_now;
         if (!stopped_now) begin
            if (is_stop) begin
               stopped_in = 1'b1;
            end else begin
               q_push    = 1'b1;
               wr_ptr_in = wr_ptr_ff + PTR_W'(1);
               if (pos_now < POS_W'(MAX_KEY_LENGTH)) begin
                  position_in = pos_now + POS_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         wr_ptr_ff   <= '0;
         stopped_ff  <= 1'b0;
      end else begin
         position_ff <= position_in;
         wr_ptr_ff   <= wr_ptr_in;
         stopped_ff  <= stopped_in;
      end
   end
endmodule

### rtl/akv_queue.sv
`timescale 1ns / 1ps
module akv_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  akv_pkg::work_type push_data,
   output logic              full,
   input  logic              pop,
   output akv_pkg::work_type pop_data,
   output logic              empty
);
   import akv_pkg::*;

   work_type   slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

### rtl/akv_back.sv
`timescale 1ns / 1ps
module akv_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  akv_pkg::work_type q_data,
   output logic              q_pop,
   akv_rsp_if.source         rsp_link
);
   import akv_pkg::*;

   logic [TEXT_W-1:0]     ring_ff [MAX_KEY_LENGTH];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TEXT_W-1:0]     rsp_char_ff;
   logic [KEY_BYTE_W-1:0] shift;
   logic [SUM_W-1:0]      sum;
   logic [TEXT_W-1:0]     result;
   logic [TEXT_W-1:0]     plain;

   assign q_pop = !q_empty && (!rsp_valid_ff || rsp_link.ready);

   always_comb begin
      shift = q_data.use_key ? q_data.key_byte
                             : {1'b0, ring_ff[q_data.rd_idx]};
      if (q_data.mode == MODE_DECRYPT) begin
         sum = SUM_W'(q_data.text_char) + DEC_BIAS - SUM_W'(shift);
      end else begin
         sum = SUM_W'(q_data.text_char) + SUM_W'(shift) + ENC_BIAS;
      end
      result = wrap_printable(sum);
      // the ring keeps plaintext: the input when enciphering, the result when deciphering
      plain  = (q_data.mode == MODE_DECRYPT) ? result : q_data.text_char;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_link.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ring_ff[q_data.wr_idx] <= plain;
         rsp_char_ff            <= result;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_link.valid    = rsp_valid_ff;
   assign rsp_link.out_char = rsp_char_ff;
endmodule

### rtl/autokey_vigenere_cipher.sv
`timescale 1ns / 1ps
// Autokey Vigenere cipher over printable ASCII (32..127).
// req_link carries one character per beat plus a flag marking the first
// character of a message; rsp_link returns zero or one character per beat.
// The csr_ APB port holds mode, key length and two 64-bit key words at
// byte addresses 0, 8, 16 and 24; pready is tied high.
// A character that gives a result is written into the queue, then popped into
// the output register, and shows on rsp_link from there. Throughput is one
// character per cycle while rsp_link is ready, set by the combinational ring
// read plus modulo-96 add or subtract in the back stage, which lets a character
// key off the one right before it.
// A newline in encrypt mode, and every character after it up to the next
// message start, is taken and gives no beat.
// When rsp_link stalls, the output register holds its beat, the two-entry
// queue fills, and req_link.ready drops once the queue is full.
// Reset (synchronous) loads the default key and mode, clears message
// position and queue; the history ring is not cleared.
module autokey_vigenere_cipher (
   input  logic                           clock,
   input  logic                           reset,
   akv_req_if.sink                        req_link,
   akv_rsp_if.source                      rsp_link,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [akv_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [akv_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [akv_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import akv_pkg::*;

   cfg_type  cfg;
   work_type push_data;
   work_type pop_data;
   logic     q_push;
   logic     q_pop;
   logic     q_full;
   logic     q_empty;

   akv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   akv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_link (req_link),
      .cfg      (cfg),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (push_data)
   );

   akv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   akv_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (pop_data),
      .q_pop    (q_pop),
      .rsp_link (rsp_link)
   );
endmodule

### test/autokey_vigenere_cipher_tb.sv
`timescale 1ns / 1ps
module autokey_vigenere_cipher_tb;
   import akv_pkg::*;

   localparam int ITEM_GOAL      = 1950;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_PERCENT   = 26;

   typedef enum logic {STEP_CHAR, STEP_CSR} step_kind_type;
   // where the expected result of a beat comes from
   typedef enum logic [1:0] {CHECK_MODEL, CHECK_ONE, CHECK_NONE} check_type;

   typedef struct packed {
      step_kind_type          kind;
      logic [TEXT_W-1:0]      text;
      logic                   first;
      check_type              check;
      logic [TEXT_W-1:0]      want;
      reg_index_type          reg_idx;
      logic [CSR_DATA_W-1:0]  value;
   } step_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   akv_req_if req_link ();
   akv_rsp_if rsp_link ();

   autokey_vigenere_cipher u_top (
      .clock       (clock),
      .reset       (reset),
      .req_link    (req_link),
      .rsp_link    (rsp_link),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // cipher settings as the block should hold them
   mode_type              cfg_mode;
   logic [KEY_LEN_W-1:0]  cfg_key_len;
   logic [CSR_DATA_W-1:0] cfg_key_lo;
   logic [CSR_DATA_W-1:0] cfg_key_hi;

   // message progress and plaintext history
   int unsigned       msg_pos;
   logic [TEXT_W-1:0] hist [MAX_KEY_LENGTH];
   logic [PTR_W-1:0]  hist_wr;
   int unsigned       hist_fill;
   bit                msg_halted;

   logic [TEXT_W-1:0] exp_chars [$];
   int unsigned       items_sent;
   int unsigned       mismatches;
   int unsigned       quiet_cycles;
   bit                steady;
   check_type         row_check;
   logic [TEXT_W-1:0] row_want;
   step_type          steps [$];

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic bit cipher_char(input logic [TEXT_W-1:0] ch, input logic first,
                                      output logic [TEXT_W-1:0] res);
      int unsigned klen;
      int unsigned shift;
      int unsigned sum;
      res  = '0;
      klen = cfg_key_len;
      if (klen < 1) begin
         klen = 1;
      end
      if (klen > MAX_KEY_LENGTH) begin
         klen = MAX_KEY_LENGTH;
      end
      if (first) begin
         msg_pos    = 0;
         msg_halted = 0;
      end
      if (msg_halted) begin
         return 0;
      end
      if (cfg_mode == MODE_ENCRYPT && ch == NEWLINE_CHAR) begin
         msg_halted = 1;
         return 0;
      end
      if (msg_pos < klen) begin
         shift = (msg_pos < 8) ? cfg_key_lo[8*msg_pos +: 8] : cfg_key_hi[8*(msg_pos-8) +: 8];
      end else begin
         shift = hist[PTR_W'(hist_wr + MAX_KEY_LENGTH - klen)];
      end
      if (cfg_mode == MODE_DECRYPT) begin
         sum = ch + DEC_BIAS - shift;
      end else begin
         sum = ch + shift + ENC_BIAS;
      end
      res = TEXT_W'(sum % ALPHA_SIZE + ALPHA_BASE);
      // history always holds plaintext
      hist[hist_wr] = (cfg_mode == MODE_DECRYPT) ? res : ch;
      hist_wr = hist_wr + PTR_W'(1);
      if (msg_pos < MAX_KEY_LENGTH) begin
         msg_pos++;
      end
      if (hist_fill < MAX_KEY_LENGTH) begin
         hist_fill++;
      end
      return 1;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_key();
      logic [CSR_DATA_W-1:0] key;
      case ($urandom_range(0, 4))
         0: key = {$urandom, $urandom};
         1: key = '0;
         2: key = '1;
         default: begin
            for (int i = 0; i < 8; i++) begin
               key[8*i +: 8] = 8'($urandom_range(32, 127));
            end
         end
      endcase
      return key;
   endfunction

   task automatic add_char(input logic [TEXT_W-1:0] text, input logic first,
                           input check_type check, input logic [TEXT_W-1:0] want);
      step_type s;
      s         = '0;
      s.kind    = STEP_CHAR;
      s.text    = text;
      s.first   = first;
      s.check   = check;
      s.want    = want;
      steps.push_back(s);
   endtask

   task automatic add_csr(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      step_type s;
      s         = '0;
      s.kind    = STEP_CSR;
      s.reg_idx = idx;
      s.value   = value;
      steps.push_back(s);
   endtask

   task automatic send_char(input logic [TEXT_W-1:0] ch, input logic first,
                            input check_type check, input logic [TEXT_W-1:0] want);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_link.valid <= 1'b0;
         @(posedge clock);
      end
      req_link.valid            <= 1'b1;
      req_link.text_char        <= ch;
      req_link.first_of_message <= first;
      row_check                 <= check;
      row_want                  <= want;
      do @(posedge clock); while (!req_link.ready);
      items_sent++;
   endtask

   // hold the sender until every expected beat is back
   task automatic hold_until_drained();
      req_link.valid <= 1'b0;
      @(posedge clock);
      while (exp_chars.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic drain();
      hold_until_drained();
      // newlines still in flight give no beat
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_MODE:       cfg_mode    = mode_type'(value[0]);
         REG_KEY_LENGTH: cfg_key_len = value[KEY_LEN_W-1:0];
         REG_KEY_LOW:    cfg_key_lo  = value;
         REG_KEY_HIGH:   cfg_key_hi  = value;
         default:        ;
      endcase
   endtask

   always @(posedge clock) begin : monitor
      logic [TEXT_W-1:0] predicted;
      logic [TEXT_W-1:0] expected;
      bit                produces;
      bit                req_beat;
      bit                rsp_beat;
      req_beat = !reset && req_link.valid && req_link.ready;
      rsp_beat = !reset && rsp_link.valid && rsp_link.ready;
      if (req_beat) begin
         produces = cipher_char(req_link.text_char, req_link.first_of_message, predicted);
         if (row_check == CHECK_ONE) begin
            exp_chars.push_back(row_want);
         end else if (row_check == CHECK_MODEL && produces) begin
            exp_chars.push_back(predicted);
         end
      end
      if (rsp_beat) begin
         if (exp_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected out_char %0d", rsp_link.out_char);
            end
         end else begin
            expected = exp_chars.pop_front();
            if (rsp_link.out_char !== expected) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("out_char mismatch: expected %0d got %0d",
                           expected, rsp_link.out_char);
               end
            end
         end
      end
      if (req_beat || rsp_beat) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      rsp_link.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   initial begin
      int unsigned           phase;
      int unsigned           quota;
      int unsigned           sent;
      int unsigned           len;
      bit                    fresh;
      bit                    ends_newline;
      logic [TEXT_W-1:0]     ch;
      logic [KEY_LEN_W-1:0]  klen;

      reset                     <= 1'b1;
      req_link.valid            <= 1'b0;
      req_link.text_char        <= '0;
      req_link.first_of_message <= 1'b0;
      csr_psel                  <= 1'b0;
      csr_penable               <= 1'b0;
      csr_pwrite                <= 1'b0;
      csr_paddr                 <= '0;
      csr_pwdata                <= '0;
      row_check                 <= CHECK_MODEL;
      row_want                  <= '0;
      cfg_mode          = MODE_ENCRYPT;
      cfg_key_len       = KEY_LEN_RESET;
      cfg_key_lo        = KEY_LOW_RESET;
      cfg_key_hi        = KEY_HIGH_RESET;
      msg_pos           = 0;
      hist_wr           = '0;
      hist_fill         = 0;
      msg_halted        = 0;
      items_sent        = 0;
      mismatches        = 0;
      quiet_cycles      = 0;
      steady            = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // default key "deceptive": a space maps onto the key character itself
      add_char(7'd32,  1'b1, CHECK_ONE,  7'd100);
      add_char(7'd127, 1'b0, CHECK_ONE,  7'd100);
      add_char(7'd0,   1'b0, CHECK_ONE,  7'd67);
      add_char(TEXT_W'("H"), 1'b0, CHECK_MODEL, '0);
      add_char(TEXT_W'("e"), 1'b0, CHECK_MODEL, '0);
      add_char(TEXT_W'("l"), 1'b0, CHECK_MODEL, '0);
      add_char(TEXT_W'("l"), 1'b0, CHECK_MODEL, '0);
      add_char(TEXT_W'("o"), 1'b0, CHECK_MODEL, '0);
      add_char(TEXT_W'("~"), 1'b0, CHECK_MODEL, '0);
      add_char(TEXT_W'("W"), 1'b0, CHECK_MODEL, '0);
      add_char(NEWLINE_CHAR, 1'b0, CHECK_NONE, '0);
      add_char(TEXT_W'("x"), 1'b0, CHECK_NONE, '0);
      add_char(TEXT_W'("a"), 1'b1, CHECK_MODEL, '0);
      // zero key length acts as one; key bytes outside the printable range
      add_csr(REG_KEY_LENGTH, 64'd0);
      add_csr(REG_KEY_LOW, 64'h00FF_8013_7F20_41FF);
      add_char(TEXT_W'("Q"), 1'b1, CHECK_MODEL, '0);
      add_char(TEXT_W'("R"), 1'b0, CHECK_MODEL, '0);
      add_char(TEXT_W'("S"), 1'b0, CHECK_MODEL, '0);
      // change the key length in the middle of a message
      add_csr(REG_KEY_LENGTH, 64'd31);
      add_csr(REG_KEY_HIGH, 64'hFFFF_0000_7F20_0A01);
      add_char(TEXT_W'("T"), 1'b0, CHECK_MODEL, '0);
      add_char(TEXT_W'("U"), 1'b0, CHECK_MODEL, '0);
      add_csr(REG_KEY_LENGTH, 64'd2);
      add_char(TEXT_W'("V"), 1'b0, CHECK_MODEL, '0);
      // decrypt passes a newline through
      add_csr(REG_MODE, 64'(MODE_DECRYPT));
      add_char(NEWLINE_CHAR, 1'b1, CHECK_MODEL, '0);
      add_char(7'd127, 1'b0, CHECK_MODEL, '0);
      add_char(7'd0,   1'b0, CHECK_MODEL, '0);
      add_char(7'd32,  1'b0, CHECK_MODEL, '0);
      // a message halted in encrypt stays silent in decrypt
      add_csr(REG_MODE, 64'(MODE_ENCRYPT));
      add_char(NEWLINE_CHAR, 1'b0, CHECK_NONE, '0);
      add_csr(REG_MODE, 64'(MODE_DECRYPT));
      add_char(TEXT_W'("z"), 1'b0, CHECK_NONE, '0);
      add_char(TEXT_W'("z"), 1'b1, CHECK_MODEL, '0);

      foreach (steps[i]) begin
         if (steps[i].kind == STEP_CSR) begin
            drain();
            write_csr(steps[i].reg_idx, steps[i].value);
         end else begin
            send_char(steps[i].text, steps[i].first, steps[i].check, steps[i].want);
         end
      end

      drain();
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         steady = (phase >= 5 && phase <= 7);
         drain();
         if (phase == 0 || $urandom_range(0, 2) != 0) begin
            write_csr(REG_MODE, 64'($urandom_range(0, 1)));
         end
         if (phase == 0 || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 5))
               0: klen = 5'd0;
               1: klen = 5'd1;
               2: klen = 5'd16;
               3: klen = 5'd31;
               default: klen = KEY_LEN_W'($urandom_range(2, 15));
            endcase
            write_csr(REG_KEY_LENGTH, 64'(klen));
         end
         if (phase == 0 || $urandom_range(0, 2) == 0) begin
            write_csr(REG_KEY_LOW, random_key());
         end
         if (phase == 0 || $urandom_range(0, 2) == 0) begin
            write_csr(REG_KEY_HIGH, random_key());
         end
         quota = $urandom_range(40, 140);
         sent  = 0;
         while (sent < quota) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            // carry a message across only once the whole history is written
            fresh = !(hist_fill == MAX_KEY_LENGTH && $urandom_range(0, 5) == 0);
            ends_newline = (cfg_mode == MODE_ENCRYPT) && ($urandom_range(0, 2) == 0);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  ch = TEXT_W'($urandom_range(0, 127));
               end else begin
                  ch = TEXT_W'($urandom_range(32, 127));
               end
               send_char(ch, (i == 0 && fresh) || $urandom_range(0, 59) == 0, CHECK_MODEL, '0);
            end
            if (ends_newline) begin
               send_char(NEWLINE_CHAR, 1'b0, CHECK_MODEL, '0);
               repeat ($urandom_range(0, 3)) begin
                  ch = TEXT_W'($urandom_range(0, 127));
                  send_char(ch, 1'b0, CHECK_MODEL, '0);
               end
            end
            sent += len;
            if ($urandom_range(0, 7) == 0) begin
               hold_until_drained();
            end
         end
         phase++;
      end

      drain();
      if (mismatches == 0 && exp_chars.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
